FILE: rtl/core/slc_pkg.sv
// types and constants shared by the sprite layer compositor
package slc_pkg;

    localparam int unsigned CFG_IDX_W = 1;

    typedef enum logic [1:0] {
        OP_LOAD_ATTR = 2'd0,
        OP_LOAD_PAL  = 2'd1,
        OP_LOAD_ROW  = 2'd2,
        OP_COMPOSE   = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAYER_COUNT = 1'd0,
        CFG_BACKGROUND  = 1'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_FETCH = 2'd1,
        ST_TEST  = 2'd2,
        ST_PAL   = 2'd3
    } t_back_state;

    typedef struct packed {
        logic [1:0]  operation;
        logic [2:0]  layer;
        logic [5:0]  entry_index;
        logic [8:0]  x_pos;
        logic [8:0]  y_pos;
        logic [8:0]  sprite_width;
        logic [8:0]  sprite_height;
        logic [15:0] color_value;
        logic [31:0] pixel_word;
        logic [8:0]  pixel_row;
        logic [8:0]  pixel_column;
    } t_in_item;

    typedef struct packed {
        logic [15:0] pixel_color;
        logic [8:0]  column_out;
        logic        opaque_hit;
    } t_out_item;

    typedef struct packed {
        logic        empty;
        logic        full;
    } t_fifo_status;

endpackage

FILE: rtl/core/slc_queue.sv
// short item queue between the front decode and the back engine
module slc_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  slc_pkg::t_in_item  i_data,
    input  logic               i_pop,
    output slc_pkg::t_in_item  o_data,
    output slc_pkg::t_fifo_status o_status
);
    import slc_pkg::*;

    t_in_item   r_mem [2];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp ^ i_push;
        n_rp  = r_rp ^ i_pop;
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data          = r_mem[r_rp];
    assign o_status.empty  = (r_cnt == 2'd0);
    assign o_status.full   = (r_cnt == 2'd2);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full |-> !i_push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.empty |-> !i_pop) else $error("queue underflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
endmodule

FILE: rtl/core/slc_back.sv
// back engine: table writes and the per-layer compose walk
module slc_back #(
    parameter int unsigned MAX_LAYER_COUNT = 8,
    parameter int unsigned SCREEN_WIDTH    = 320
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  slc_pkg::t_fifo_status i_q_status,
    input  slc_pkg::t_in_item  i_item,
    output logic               o_pop,
    input  logic [3:0]         i_layer_count,
    input  logic [15:0]        i_background,
    output logic               o_idle,
    output logic               o_strobe,
    output slc_pkg::t_out_item o_result
);
    import slc_pkg::*;

    localparam int unsigned ROW_WORDS = (SCREEN_WIDTH + 7) / 8;
    localparam int unsigned LW = (MAX_LAYER_COUNT > 1) ? $clog2(MAX_LAYER_COUNT) : 1;
    localparam int unsigned WW = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
    localparam int unsigned CW = $clog2(MAX_LAYER_COUNT + 1);
    localparam int unsigned PAL_DEPTH = MAX_LAYER_COUNT * 16;
    localparam int unsigned ROW_DEPTH = MAX_LAYER_COUNT * (1 << WW);

    // attributes: x, y, w, h per layer
    logic [35:0] r_attr [MAX_LAYER_COUNT];
    logic [15:0] r_pal  [PAL_DEPTH];
    logic [31:0] r_row  [ROW_DEPTH];

    t_back_state r_state, n_state;
    logic [CW-1:0] r_lay, n_lay, r_n, n_n;
    logic [8:0]    r_prow, r_pcol;
    logic [35:0]   r_a;
    logic [31:0]   r_word;
    logic [15:0]   r_pcol_rd;
    logic [3:0]    r_nib;
    logic          r_inside;
    logic          r_strobe, n_strobe;
    t_out_item     r_res, n_res;
    logic [LW-1:0] lay_idx;
    logic [8:0]    off;
    logic [9:0]    xe, ye;
    logic          in_rect;
    logic [3:0]    nib;
    logic          start_cmp;
    logic [WW-1:0] widx;
    logic          r_decide, n_decide;

    assign lay_idx = r_lay[LW-1:0];
    assign xe  = {1'b0, r_a[35:27]} + {1'b0, r_a[17:9]};
    assign ye  = {1'b0, r_a[26:18]} + {1'b0, r_a[8:0]};
    assign off = r_pcol - r_a[35:27];
    assign in_rect = (r_prow >= r_a[26:18]) && ({1'b0, r_prow} < ye)
                  && (r_pcol >= r_a[35:27]) && ({1'b0, r_pcol} < xe)
                  && ({3'd0, off[8:3]} < 9'(ROW_WORDS));
    assign widx = WW'(off[8:3]);
    assign nib = 4'(r_word >> {off[2:0], 2'b00});
    assign start_cmp = (r_state == ST_IDLE) && !r_decide && !i_q_status.empty
                    && (t_op'(i_item.operation) == OP_COMPOSE);

    // memory writes and registered reads
    always_ff @(posedge i_clk) begin
        if (o_pop && {2'b00, i_item.layer} < 5'(MAX_LAYER_COUNT)) begin
            unique case (t_op'(i_item.operation))
                OP_LOAD_ATTR: r_attr[LW'(i_item.layer)] <= {i_item.x_pos, i_item.y_pos,
                    i_item.sprite_width, i_item.sprite_height};
                OP_LOAD_PAL: if (i_item.entry_index >= 6'd1 && i_item.entry_index <= 6'd15)
                    r_pal[{LW'(i_item.layer), i_item.entry_index[3:0]}] <= i_item.color_value;
                OP_LOAD_ROW: if ({3'd0, i_item.entry_index} < 9'(ROW_WORDS))
                    r_row[{LW'(i_item.layer), WW'(i_item.entry_index)}] <= i_item.pixel_word;
                default: ;
            endcase
        end
        if (r_state == ST_FETCH) begin
            r_a <= r_attr[lay_idx];
        end
        if (r_state == ST_TEST) begin
            r_word   <= r_row[{lay_idx, widx}];
            r_inside <= in_rect;
        end
        if (r_state == ST_PAL) begin
            r_pcol_rd <= r_pal[{lay_idx, nib}];
            r_nib     <= nib;
        end
        if (start_cmp) begin
            r_prow <= i_item.pixel_row;
            r_pcol <= i_item.pixel_column;
        end
    end

    // walk: FETCH reads attributes, TEST checks bounds and reads the word,
    // PAL picks the nibble and reads the palette, then IDLE-side decision
    always_comb begin
        n_state  = r_state;
        n_lay    = r_lay;
        n_n      = r_n;
        n_strobe = 1'b0;
        n_res    = r_res;
        n_decide = 1'b0;
        o_pop    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (r_decide) begin
                    if (r_inside && r_nib != 4'd0) begin
                        n_strobe = 1'b1;
                        n_res = '{pixel_color: r_pcol_rd, column_out: r_pcol, opaque_hit: 1'b1};
                    end else if (r_lay + CW'(1) < r_n) begin
                        n_lay   = r_lay + CW'(1);
                        n_state = ST_FETCH;
                    end else begin
                        n_strobe = 1'b1;
                        n_res = '{pixel_color: i_background, column_out: r_pcol,
                                  opaque_hit: 1'b0};
                    end
                end else if (!i_q_status.empty) begin
                    o_pop = 1'b1;
                    if (start_cmp) begin
                        n_lay = '0;
                        n_n   = ({1'b0, i_layer_count} > 5'(MAX_LAYER_COUNT)) ?
                                CW'(MAX_LAYER_COUNT) : CW'(i_layer_count);
                        if (n_n == '0) begin
                            n_strobe = 1'b1;
                            n_res = '{pixel_color: i_background,
                                      column_out: i_item.pixel_column, opaque_hit: 1'b0};
                        end else begin
                            n_state = ST_FETCH;
                        end
                    end
                end
            end
            ST_FETCH: n_state = ST_TEST;
            ST_TEST:  n_state = ST_PAL;
            ST_PAL: begin
                n_state  = ST_IDLE;
                n_decide = 1'b1;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
            r_decide <= 1'b0;
            r_lay    <= '0;
            r_n      <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_decide <= n_decide;
            r_lay    <= n_lay;
            r_n      <= n_n;
        end
        r_res <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;
    assign o_idle   = (r_state == ST_IDLE) && !r_decide && i_q_status.empty && !r_strobe;

    a_decide_after_pal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_decide |-> $past(r_state) == ST_PAL) else $error("decide without walk");
    a_layer_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> r_lay < r_n) else $error("layer past count");
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> r_state == ST_IDLE || $past(r_decide) == 1'b0)
        else $error("strobe during walk");
endmodule

FILE: rtl/core/sprite_layer_compositor.sv
// top level of the sprite layer compositor
// a load leaves the queue once the back engine is idle and gives no result
// a compose tests layers in order, reading attribute, row word and palette, then deciding per layer
// with no layers enabled, the background result is strobed straight from the pop
// one item is in the back engine at a time
// start is taken while the two-entry queue has room; results cannot be stalled
// synchronous active-low reset clears control and config; tables are undefined until loaded
module sprite_layer_compositor #(
    parameter int unsigned MAX_LAYER_COUNT = 8,
    parameter int unsigned SCREEN_WIDTH    = 320
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  slc_pkg::t_in_item  i_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [slc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic               o_strobe,
    output slc_pkg::t_out_item o_result
);
    import slc_pkg::*;

    logic [3:0]   r_layer_count;
    logic [15:0]  r_background;
    t_fifo_status q_status;
    t_in_item     q_data;
    logic         pop, idle;

    assign busy        = q_status.full;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer_count <= 4'd0;
            r_background  <= 16'd0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LAYER_COUNT: r_layer_count <= i_cfg_data[3:0];
                CFG_BACKGROUND:  r_background  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    slc_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(start && !busy), .i_data(i_item),
        .i_pop(pop), .o_data(q_data), .o_status(q_status)
    );

    slc_back #(.MAX_LAYER_COUNT(MAX_LAYER_COUNT), .SCREEN_WIDTH(SCREEN_WIDTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_status(q_status), .i_item(q_data), .o_pop(pop),
        .i_layer_count(r_layer_count), .i_background(r_background),
        .o_idle(idle), .o_strobe(o_strobe), .o_result(o_result)
    );

    a_cfg_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> idle || !start) else $error("config write while busy");
    a_busy_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !idle) else $error("busy while idle");
    a_no_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(idle) && idle |-> !o_strobe) else $error("result from nowhere");
endmodule
